// ----- rtl/core/awbs_pkg.sv -----
// ----------------------------------------------------------------------------
// awbs_pkg
// Shared widths, latencies and constants of the A-weighted octave band
// summation datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package awbs_pkg;

  // band count supported by the port list
  localparam int NUM_BANDS_MAX = 8;

  // level widths: input levels and levels after A-weighting
  localparam int LEVEL_W  = 12;
  localparam int WLEVEL_W = 14;

  // attenuation: difference bits that matter and Q30 accumulator width
  localparam int ATTEN_BITS = 10;
  localparam int ACC_W      = 31;
  localparam int SUM_W      = ACC_W + 3;

  // log2 stage: fraction bits, exponent width, correction width
  localparam int LOG_FRAC_BITS = 20;
  localparam int LOG_E_W       = 2;
  localparam int LOG2_W        = LOG_E_W + LOG_FRAC_BITS;
  localparam int DB_W          = 21;
  localparam int CORR_W        = 8;

  // pipeline depths in clock cycles
  localparam int LANE_LAT   = ATTEN_BITS + 1;
  localparam int MERGE_LAT  = LOG_FRAC_BITS + 3;
  localparam int FRONT_LAT  = 2;
  localparam int RESULT_LAT = FRONT_LAT + LANE_LAT + MERGE_LAT + 1;

  // Q30 constants
  localparam logic [ACC_W-1:0] ONE_Q30        = ACC_W'(64'd1 << 30);
  localparam logic [ACC_W-1:0] TENTH_STEP_Q30 = 31'd1049300476;
  localparam logic [63:0]      HALF_Q30       = 64'd1 << 29;

  // 100*log10(2) in Q16
  localparam logic [DB_W-1:0] DB_PER_OCTAVE_Q16 = 21'd1972830;

  // A-weighting correction per band, tenths of a dB
  localparam logic signed [WLEVEL_W-1:0] A_CORR [NUM_BANDS_MAX] = '{
    -14'sd262, -14'sd161, -14'sd86, -14'sd32,
     14'sd0,    14'sd12,   14'sd10, -14'sd11
  };

  // output limits
  localparam logic signed [WLEVEL_W:0] OUT_MIN = -15'sd2048;
  localparam logic signed [WLEVEL_W:0] OUT_MAX =  15'sd2047;

  // 10^(-2^k/100) in Q30, by repeated rounded squaring of the 0.1 dB step
  function automatic logic [ACC_W-1:0] step_pow(input int k);
    logic [63:0] p;
    p = {33'd0, TENTH_STEP_Q30};
    for (int i = 0; i < k; i++) begin
      p = (p * p + HALF_Q30) >> 30;
    end
    return p[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/a_weighted_octave_band_sum_top.sv -----
// ----------------------------------------------------------------------------
// a_weighted_octave_band_sum_top
// A-weighted total level of one octave-band spectrum.
// ----------------------------------------------------------------------------
// The block takes one spectrum of octave-band levels (63 Hz to 8 kHz, signed
// tenths of a dB) each cycle that start_i is high; busy_o stays low, so an
// item may follow in every cycle. Each item gives one total_level_o, shown
// for exactly one cycle with done_o high. The result passes through two
// front stages (weighting, loudest band), in each band lane one difference
// stage and ten multiply stages, one summing stage, one normalising stage,
// twenty squaring stages for the log2 fraction and one scaling stage, then
// the output register. The receiver cannot stall the output, so each
// result must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module a_weighted_octave_band_sum_top #(
  parameter int NUM_BANDS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_63_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_125_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_250_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_500_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_1k_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_2k_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_4k_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_8k_level_i,
  output logic                                done_o,
  output logic signed [awbs_pkg::LEVEL_W-1:0] total_level_o
);

  import awbs_pkg::*;

  localparam int VLD_DEPTH = FRONT_LAT + LANE_LAT + MERGE_LAT;
  localparam int MAX_DEPTH = LANE_LAT + MERGE_LAT;

  logic signed [LEVEL_W-1:0]  lvl     [NUM_BANDS_MAX];
  logic signed [WLEVEL_W-1:0] w1_q    [NUM_BANDS];
  logic signed [WLEVEL_W-1:0] w2_q    [NUM_BANDS];
  logic signed [WLEVEL_W-1:0] max_d;
  logic signed [WLEVEL_W-1:0] max_q;
  logic signed [WLEVEL_W-1:0] mline_q [MAX_DEPTH];
  logic [ACC_W-1:0]           terms   [NUM_BANDS];
  logic [CORR_W-1:0]          corr;
  logic [VLD_DEPTH-1:0]       vld_q;
  logic                       done_q;
  logic signed [WLEVEL_W:0]   total;
  logic signed [LEVEL_W-1:0]  total_d;
  logic signed [LEVEL_W-1:0]  total_q;
  logic                       accept;

  // every cycle can take an item
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign lvl[0] = band_63_level_i;
  assign lvl[1] = band_125_level_i;
  assign lvl[2] = band_250_level_i;
  assign lvl[3] = band_500_level_i;
  assign lvl[4] = band_1k_level_i;
  assign lvl[5] = band_2k_level_i;
  assign lvl[6] = band_4k_level_i;
  assign lvl[7] = band_8k_level_i;

  // item valid bits travel beside the payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[VLD_DEPTH-2:0], accept};
      done_q <= vld_q[VLD_DEPTH-1];
    end
  end

  // front stage one: add the A-weighting correction
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_BANDS; i++) begin
      w1_q[i] <= {{(WLEVEL_W-LEVEL_W){lvl[i][LEVEL_W-1]}}, lvl[i]} + A_CORR[i];
    end
  end

  // front stage two: loudest weighted band
  always_comb begin
    max_d = w1_q[0];
    for (int i = 1; i < NUM_BANDS; i++) begin
      if (w1_q[i] > max_d) begin
        max_d = w1_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    w2_q  <= w1_q;
  end

  // band lanes
  for (genvar b = 0; b < NUM_BANDS; b++) begin : g_lane
    awbs_lane u_lane (
      .clk_i      (clk_i),
      .max_i      (max_q),
      .weighted_i (w2_q[b]),
      .term_o     (terms[b])
    );
  end

  // sum, log2 and scaling
  awbs_merge #(
    .NUM_BANDS (NUM_BANDS)
  ) u_merge (
    .clk_i   (clk_i),
    .terms_i (terms),
    .corr_o  (corr)
  );

  // loudest level delayed to meet its correction
  always_ff @(posedge clk_i) begin
    mline_q[0] <= max_q;
    for (int j = 1; j < MAX_DEPTH; j++) begin
      mline_q[j] <= mline_q[j-1];
    end
  end

  // total and saturation
  assign total = {mline_q[MAX_DEPTH-1][WLEVEL_W-1], mline_q[MAX_DEPTH-1]}
               + {{(WLEVEL_W+1-CORR_W){1'b0}}, corr};

  always_comb begin
    priority if (total < OUT_MIN) begin
      total_d = OUT_MIN[LEVEL_W-1:0];
    end else if (total > OUT_MAX) begin
      total_d = OUT_MAX[LEVEL_W-1:0];
    end else begin
      total_d = total[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
  end

  assign done_o        = done_q;
  assign total_level_o = total_q;

endmodule

`default_nettype wire

// ----- rtl/core/awbs_lane.sv -----
// ----------------------------------------------------------------------------
// awbs_lane
// One band lane: forms the distance of the band below the loudest band and
// turns it into a linear power ratio 10^(-d/100) in Q30, one difference bit
// per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module awbs_lane (
  input  logic                                  clk_i,
  input  logic signed [awbs_pkg::WLEVEL_W-1:0]  max_i,
  input  logic signed [awbs_pkg::WLEVEL_W-1:0]  weighted_i,
  output logic        [awbs_pkg::ACC_W-1:0]     term_o
);

  import awbs_pkg::*;

  logic signed [WLEVEL_W:0]   diff;
  logic                       far;
  logic [ACC_W-1:0]           acc_q   [ATTEN_BITS+1];
  logic [ATTEN_BITS-1:0]      dbits_q [ATTEN_BITS];

  // distance below the loudest band, never negative
  assign diff = {max_i[WLEVEL_W-1], max_i} - {weighted_i[WLEVEL_W-1], weighted_i};
  assign far  = (diff[WLEVEL_W:ATTEN_BITS] != '0);

  // entry stage: bands 102.4 dB or more down contribute nothing
  always_ff @(posedge clk_i) begin
    acc_q[0]   <= far ? '0 : ONE_Q30;
    dbits_q[0] <= diff[ATTEN_BITS-1:0];
  end

  // one rounded Q30 multiply per difference bit
  for (genvar k = 0; k < ATTEN_BITS; k++) begin : g_step
    localparam logic [ACC_W-1:0] PK = step_pow(k);
    logic [2*ACC_W-1:0] prod;
    logic [2*ACC_W-1:0] prod_rnd;

    assign prod     = {{ACC_W{1'b0}}, acc_q[k]} * {{ACC_W{1'b0}}, PK};
    assign prod_rnd = prod + HALF_Q30[2*ACC_W-1:0];

    always_ff @(posedge clk_i) begin
      acc_q[k+1] <= dbits_q[k][k] ? prod_rnd[ACC_W+29:30] : acc_q[k];
    end

    if (k < ATTEN_BITS - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        dbits_q[k+1] <= dbits_q[k];
      end
    end
  end

  assign term_o = acc_q[ATTEN_BITS];

endmodule

`default_nettype wire

// ----- rtl/core/awbs_merge.sv -----
// ----------------------------------------------------------------------------
// awbs_merge
// Merging stage: sums the lane powers, takes log2 of the sum by repeated
// squaring (one fraction bit per stage) and scales it to tenths of a dB.
// ----------------------------------------------------------------------------
`default_nettype none

module awbs_merge #(
  parameter int NUM_BANDS = 8
) (
  input  logic                              clk_i,
  input  logic [awbs_pkg::ACC_W-1:0]        terms_i [NUM_BANDS],
  output logic [awbs_pkg::CORR_W-1:0]       corr_o
);

  import awbs_pkg::*;

  logic [SUM_W-1:0]          sum_d;
  logic [SUM_W-1:0]          sum_q;
  logic [ACC_W-1:0]          x0_d;
  logic [LOG_E_W-1:0]        e0_d;
  logic [ACC_W-1:0]          x_q    [LOG_FRAC_BITS];
  logic [LOG_E_W-1:0]        e_q    [LOG_FRAC_BITS+1];
  logic [LOG_FRAC_BITS-1:0]  frac_q [LOG_FRAC_BITS+1];
  logic [LOG2_W-1:0]         l2;
  logic [LOG2_W+DB_W-1:0]    scaled;
  logic [LOG2_W+DB_W:0]      scaled_rnd;
  logic [CORR_W-1:0]         corr_q;

  // energy sum of all lanes
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NUM_BANDS; i++) begin
      sum_d = sum_d + {{(SUM_W-ACC_W){1'b0}}, terms_i[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // integer part of log2: bring the sum into [1, 2) in Q30
  always_comb begin
    priority if (sum_q[SUM_W-1]) begin
      x0_d = sum_q[ACC_W+2:3];
      e0_d = LOG_E_W'(3);
    end else if (sum_q[SUM_W-2]) begin
      x0_d = sum_q[ACC_W+1:2];
      e0_d = LOG_E_W'(2);
    end else if (sum_q[SUM_W-3]) begin
      x0_d = sum_q[ACC_W:1];
      e0_d = LOG_E_W'(1);
    end else begin
      x0_d = sum_q[ACC_W-1:0];
      e0_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x0_d;
    e_q[0]    <= e0_d;
    frac_q[0] <= '0;
  end

  // fraction of log2: square, renormalise, shift in one bit per stage
  for (genvar j = 0; j < LOG_FRAC_BITS; j++) begin : g_frac
    logic [2*ACC_W-1:0] sq;
    logic [2*ACC_W-1:0] sq_rnd;
    logic [ACC_W:0]     y;

    assign sq     = {{ACC_W{1'b0}}, x_q[j]} * {{ACC_W{1'b0}}, x_q[j]};
    assign sq_rnd = sq + HALF_Q30[2*ACC_W-1:0];
    assign y      = sq_rnd[ACC_W+30:30];

    always_ff @(posedge clk_i) begin
      e_q[j+1]    <= e_q[j];
      frac_q[j+1] <= {frac_q[j][LOG_FRAC_BITS-2:0], y[ACC_W]};
    end

    // the last stage only needs its fraction bit
    if (j < LOG_FRAC_BITS - 1) begin : g_next
      always_ff @(posedge clk_i) begin
        x_q[j+1] <= y[ACC_W] ? y[ACC_W:1] : y[ACC_W-1:0];
      end
    end
  end

  // scale log2 to tenths of a dB with rounding
  assign l2         = {e_q[LOG_FRAC_BITS], frac_q[LOG_FRAC_BITS]};
  assign scaled     = {{DB_W{1'b0}}, l2} * {{LOG2_W{1'b0}}, DB_PER_OCTAVE_Q16};
  assign scaled_rnd = {1'b0, scaled} + ((LOG2_W+DB_W+1)'(1) << 35);

  always_ff @(posedge clk_i) begin
    corr_q <= scaled_rnd[CORR_W+35:36];
  end

  assign corr_o = corr_q;

endmodule

`default_nettype wire

// ----- rtl/core/awbs_checker.sv -----
// ----------------------------------------------------------------------------
// awbs_checker
// Port-level checks of the A-weighted band summation: fixed latency, no
// lost or invented results, and equal spectra giving equal totals.
// ----------------------------------------------------------------------------
`default_nettype none

module awbs_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_o,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_63_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_125_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_250_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_500_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_1k_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_2k_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_4k_level_i,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] band_8k_level_i,
  input  logic                                done_o,
  input  logic signed [awbs_pkg::LEVEL_W-1:0] total_level_o
);

  import awbs_pkg::*;

  localparam int LAT = RESULT_LAT;

  // the block never holds off an item
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  // every accepted item gives its result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("result missing");

  // no result without an item accepted the same latency earlier
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without item");

  // back-to-back equal spectra give equal totals
  a_same_in_same_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o)
      && ($past(band_63_level_i, LAT)  == $past(band_63_level_i, LAT + 1))
      && ($past(band_125_level_i, LAT) == $past(band_125_level_i, LAT + 1))
      && ($past(band_250_level_i, LAT) == $past(band_250_level_i, LAT + 1))
      && ($past(band_500_level_i, LAT) == $past(band_500_level_i, LAT + 1))
      && ($past(band_1k_level_i, LAT)  == $past(band_1k_level_i, LAT + 1))
      && ($past(band_2k_level_i, LAT)  == $past(band_2k_level_i, LAT + 1))
      && ($past(band_4k_level_i, LAT)  == $past(band_4k_level_i, LAT + 1))
      && ($past(band_8k_level_i, LAT)  == $past(band_8k_level_i, LAT + 1)))
    |-> (total_level_o == $past(total_level_o)))
    else $error("equal spectra gave different totals");

endmodule

bind a_weighted_octave_band_sum_top awbs_checker u_awbs_checker (.*);

`default_nettype wire
